// ===== rtl/fm_index_search_locate_assert.svh =====
// assertion macros for the fm index rtl
`ifndef FM_INDEX_SEARCH_LOCATE_ASSERT_SVH
`define FM_INDEX_SEARCH_LOCATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FMI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fmi_pkg.sv =====
// types and constants of the fm index search and locate block
`timescale 1ns / 1ps
`default_nettype none
package fmi_pkg;

	localparam int MaxLen = 4096;
	localparam int CntW = 13;
	localparam int RowW = 12;
	localparam int SymW = 8;
	localparam int CodeW = 8;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_TERM_COUNT = 3'd1,
		ST_PAT_ZERO = 3'd2,
		ST_NOT_BUILT = 3'd3,
		ST_LOC_LOOP = 3'd4,
		ST_LOAD_FULL = 3'd5,
		ST_ROW_RANGE = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DONE,
		S_B_CLR,
		S_B_CNT_RD,
		S_B_CNT_TL,
		S_B_CNT_WR,
		S_B_PFX_RD,
		S_B_PFX_WR,
		S_B_LF_RD,
		S_B_LF_TL,
		S_B_LF_WR,
		S_B_MOD,
		S_B_MK_RD,
		S_B_MK_EV,
		S_B_SP_RD,
		S_B_SP_EV,
		S_S_FC,
		S_S_RD,
		S_S_EV,
		S_L_RD,
		S_L_EV
	} state_t;

	// byte b other than the terminator is kept as b-1
	function automatic logic [CodeW-1:0] code_of(input logic [SymW-1:0] b);
		code_of = b - 8'd1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/fmi_if.sv =====
// valid/ready channels for commands and results
`timescale 1ns / 1ps
`default_nettype none
interface fmi_req_if;
	logic valid;
	logic ready;
	fmi_pkg::cmd_t cmd;
	logic [7:0] symbol;
	logic new_pattern;
	logic [11:0] row;
	modport source (output valid, cmd, symbol, new_pattern, row, input ready);
	modport sink (input valid, cmd, symbol, new_pattern, row, output ready);
endinterface

interface fmi_rsp_if;
	logic valid;
	logic ready;
	fmi_pkg::status_t status;
	logic [12:0] interval_low;
	logic [12:0] interval_high;
	logic [11:0] text_position;
	modport source (output valid, status, interval_low, interval_high, text_position,
		input ready);
	modport sink (input valid, status, interval_low, interval_high, text_position,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/fm_index_search_locate.sv =====
// FM index over a loaded BWT: load, build, backward search and locate
// Usage:
//  req carries one command per beat (load byte, build, search step, locate row);
//  rsp returns exactly one beat per command with status, interval and position.
//  cfg_we/cfg_data set sample_interval (reset 32); write it only while idle.
// Operation (n = loaded length, s = sample_interval):
//  load writes one byte. A search step reads every stored byte through the single
//  symbol memory read port. locate follows LF steps until it reaches a marked row.
//  build: clear, count, prefix, LF table, (n-1) mod s, then the two LF walks,
//  with one read port and one write port per table.
// req.ready is high only while the sequencer is idle; one command at a time.
// A finished result sits in the output register; if rsp stalls, the sequencer
// waits in its done state and takes no new beat until the result moves out.
// Reset clears length, terminator count, interval and built flag and sets the
// configuration register back to 32; tables are rewritten by build before any read.
`timescale 1ns / 1ps
`default_nettype none
module fm_index_search_locate (
	input wire logic clk,
	input wire logic arst_n,
	fmi_req_if.sink req,
	fmi_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [12:0] cfg_data
);

	`include "fm_index_search_locate_assert.svh"

	fmi_pkg::state_t state_q, state_d;

	logic [12:0] cnt_q, cnt_d, seen_q, seen_d, low_q, low_d, high_q, high_d, si_q;
	logic [11:0] term_q, term_d;
	logic built_q, built_d;

	logic [12:0] idx_q, idx_d, i_q, i_d, m_q, m_d, acc_q, acc_d;
	logic [12:0] rl_q, rl_d, rh_q, rh_d, steps_q, steps_d;
	logic [11:0] j_q, j_d, text_q, text_d;
	logic [7:0] code_q, code_d;
	fmi_pkg::status_t status_q, status_d;

	logic out_v_q;
	fmi_pkg::status_t o_status_q;
	logic [12:0] o_low_q, o_high_q;
	logic [11:0] o_text_q;
	logic load_out;

	// memories
	logic [7:0] sym_mem [fmi_pkg::MaxLen];
	logic [12:0] tl_mem [256];
	logic [12:0] fc_mem [256];
	logic [11:0] lf_mem [fmi_pkg::MaxLen];
	logic mk_mem [fmi_pkg::MaxLen];
	logic [11:0] sp_mem [fmi_pkg::MaxLen];

	logic sym_we, tl_we, fc_we, lf_we, mk_we, mk_wd, sp_we;
	logic [7:0] sym_wd, tl_wa, tl_ra, fc_wa, fc_ra;
	logic [12:0] tl_wd, fc_wd;
	logic [11:0] lf_wa, lf_wd, mk_wa, sp_wa, sp_wd;
	logic [7:0] sym_rd_q;
	logic [12:0] tl_rd_q, fc_rd_q;
	logic [11:0] lf_rd_q, sp_rd_q;
	logic mk_rd_q;

	logic acc_in, idx_end, is_term, lf_ok;
	logic [13:0] lf_sum;

	assign req.ready = (state_q == fmi_pkg::S_IDLE);
	assign acc_in = req.valid && req.ready;
	assign idx_end = (idx_q >= cnt_q);
	assign is_term = (idx_q[11:0] == term_q);
	assign lf_sum = {1'b0, fc_rd_q} + {1'b0, tl_rd_q};
	assign lf_ok = (lf_sum < {1'b0, cnt_q});
	assign load_out = (state_q == fmi_pkg::S_DONE) && (!out_v_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q; seen_d = seen_q; term_d = term_q;
		low_d = low_q; high_d = high_q; built_d = built_q;
		idx_d = idx_q; i_d = i_q; m_d = m_q; acc_d = acc_q; j_d = j_q;
		rl_d = rl_q; rh_d = rh_q; steps_d = steps_q; code_d = code_q;
		status_d = status_q; text_d = text_q;
		sym_we = 1'b0; sym_wd = fmi_pkg::code_of(req.symbol);
		tl_we = 1'b0; tl_wa = code_q; tl_wd = '0; tl_ra = code_q;
		fc_we = 1'b0; fc_wa = idx_q[7:0]; fc_wd = acc_q; fc_ra = code_q;
		lf_we = 1'b0; lf_wa = idx_q[11:0]; lf_wd = '0;
		mk_we = 1'b0; mk_wa = idx_q[11:0]; mk_wd = 1'b0;
		sp_we = 1'b0; sp_wa = j_q; sp_wd = i_q[11:0];
		case (state_q)
			fmi_pkg::S_IDLE: begin
				if (acc_in) begin
					status_d = fmi_pkg::ST_OK;
					text_d = '0;
					state_d = fmi_pkg::S_DONE;
					case (req.cmd)
						fmi_pkg::CMD_LOAD: begin
							if (cnt_q[12]) begin
								status_d = fmi_pkg::ST_LOAD_FULL;
							end else begin
								sym_we = 1'b1;
								if (req.symbol == 8'd0) begin
									sym_wd = 8'd0;
									term_d = cnt_q[11:0];
									seen_d = seen_q + 13'd1;
								end
								cnt_d = cnt_q + 13'd1;
								built_d = 1'b0;
							end
						end
						fmi_pkg::CMD_BUILD: begin
							if (seen_q != 13'd1) begin
								status_d = fmi_pkg::ST_TERM_COUNT;
								built_d = 1'b0;
							end else begin
								idx_d = '0;
								state_d = fmi_pkg::S_B_CLR;
							end
						end
						fmi_pkg::CMD_SEARCH: begin
							if (!built_q) begin
								status_d = fmi_pkg::ST_NOT_BUILT;
							end else if (req.symbol == 8'd0) begin
								status_d = fmi_pkg::ST_PAT_ZERO;
							end else begin
								code_d = fmi_pkg::code_of(req.symbol);
								if (req.new_pattern) begin
									low_d = '0;
									high_d = cnt_q;
								end
								state_d = fmi_pkg::S_S_FC;
							end
						end
						fmi_pkg::CMD_LOCATE: begin
							if (!built_q || si_q == 13'd0) begin
								status_d = fmi_pkg::ST_NOT_BUILT;
							end else if ({1'b0, req.row} >= cnt_q) begin
								status_d = fmi_pkg::ST_ROW_RANGE;
							end else begin
								j_d = req.row;
								steps_d = '0;
								state_d = fmi_pkg::S_L_RD;
							end
						end
						default: begin
							state_d = fmi_pkg::S_DONE;
						end
					endcase
				end
			end
			fmi_pkg::S_DONE: begin
				if (load_out) state_d = fmi_pkg::S_IDLE;
			end
			fmi_pkg::S_B_CLR: begin
				tl_we = 1'b1;
				tl_wa = idx_q[7:0];
				tl_wd = '0;
				idx_d = idx_q + 13'd1;
				if (idx_q[7:0] == 8'hFF) begin
					idx_d = '0;
					state_d = fmi_pkg::S_B_CNT_RD;
				end
			end
			fmi_pkg::S_B_CNT_RD: begin
				if (idx_end) begin
					idx_d = '0;
					acc_d = 13'd1;
					state_d = fmi_pkg::S_B_PFX_RD;
				end else begin
					state_d = fmi_pkg::S_B_CNT_TL;
				end
			end
			fmi_pkg::S_B_CNT_TL: begin
				if (is_term) begin
					idx_d = idx_q + 13'd1;
					state_d = fmi_pkg::S_B_CNT_RD;
				end else begin
					tl_ra = sym_rd_q;
					code_d = sym_rd_q;
					state_d = fmi_pkg::S_B_CNT_WR;
				end
			end
			fmi_pkg::S_B_CNT_WR: begin
				tl_we = 1'b1;
				tl_wd = tl_rd_q + 13'd1;
				idx_d = idx_q + 13'd1;
				state_d = fmi_pkg::S_B_CNT_RD;
			end
			fmi_pkg::S_B_PFX_RD: begin
				tl_ra = idx_q[7:0];
				state_d = fmi_pkg::S_B_PFX_WR;
			end
			fmi_pkg::S_B_PFX_WR: begin
				// first column entry, then clear the tally for the LF pass
				fc_we = 1'b1;
				acc_d = acc_q + tl_rd_q;
				tl_we = 1'b1;
				tl_wa = idx_q[7:0];
				tl_wd = '0;
				idx_d = idx_q + 13'd1;
				state_d = fmi_pkg::S_B_PFX_RD;
				if (idx_q[7:0] == 8'hFF) begin
					idx_d = '0;
					state_d = fmi_pkg::S_B_LF_RD;
				end
			end
			fmi_pkg::S_B_LF_RD: begin
				if (idx_end) begin
					if (si_q == 13'd0) begin
						built_d = 1'b1;
						low_d = '0;
						high_d = cnt_q;
						state_d = fmi_pkg::S_DONE;
					end else begin
						i_d = cnt_q - 13'd1;
						m_d = cnt_q - 13'd1;
						j_d = '0;
						state_d = fmi_pkg::S_B_MOD;
					end
				end else begin
					state_d = fmi_pkg::S_B_LF_TL;
				end
			end
			fmi_pkg::S_B_LF_TL: begin
				if (is_term) begin
					lf_we = 1'b1;
					lf_wd = '0;
					mk_we = 1'b1;
					idx_d = idx_q + 13'd1;
					state_d = fmi_pkg::S_B_LF_RD;
				end else begin
					fc_ra = sym_rd_q;
					tl_ra = sym_rd_q;
					code_d = sym_rd_q;
					state_d = fmi_pkg::S_B_LF_WR;
				end
			end
			fmi_pkg::S_B_LF_WR: begin
				lf_we = 1'b1;
				lf_wd = lf_ok ? lf_sum[11:0] : 12'd0;
				mk_we = 1'b1;
				tl_we = 1'b1;
				tl_wd = tl_rd_q + 13'd1;
				idx_d = idx_q + 13'd1;
				state_d = fmi_pkg::S_B_LF_RD;
			end
			fmi_pkg::S_B_MOD: begin
				// (n-1) mod s by repeated subtraction
				if (m_q >= si_q) begin
					m_d = m_q - si_q;
				end else begin
					state_d = fmi_pkg::S_B_MK_RD;
				end
			end
			fmi_pkg::S_B_MK_RD: begin
				if (i_q == 13'd0) begin
					mk_we = 1'b1;
					mk_wa = j_q;
					mk_wd = 1'b1;
					i_d = cnt_q - 13'd1;
					j_d = '0;
					state_d = fmi_pkg::S_B_SP_RD;
				end else begin
					state_d = fmi_pkg::S_B_MK_EV;
				end
			end
			fmi_pkg::S_B_MK_EV: begin
				if (m_q == 13'd0) begin
					mk_we = 1'b1;
					mk_wa = j_q;
					mk_wd = 1'b1;
				end
				m_d = (m_q == 13'd0) ? si_q - 13'd1 : m_q - 13'd1;
				j_d = lf_rd_q;
				i_d = i_q - 13'd1;
				state_d = fmi_pkg::S_B_MK_RD;
			end
			fmi_pkg::S_B_SP_RD: begin
				if (i_q == 13'd0) begin
					sp_we = 1'b1;
					sp_wd = '0;
					built_d = 1'b1;
					low_d = '0;
					high_d = cnt_q;
					state_d = fmi_pkg::S_DONE;
				end else begin
					state_d = fmi_pkg::S_B_SP_EV;
				end
			end
			fmi_pkg::S_B_SP_EV: begin
				sp_we = mk_rd_q;
				j_d = lf_rd_q;
				i_d = i_q - 13'd1;
				state_d = fmi_pkg::S_B_SP_RD;
			end
			fmi_pkg::S_S_FC: begin
				idx_d = '0;
				rl_d = '0;
				rh_d = '0;
				state_d = fmi_pkg::S_S_RD;
			end
			fmi_pkg::S_S_RD: begin
				if (idx_end) begin
					low_d = fc_rd_q + rl_q;
					high_d = fc_rd_q + rh_q;
					state_d = fmi_pkg::S_DONE;
				end else begin
					state_d = fmi_pkg::S_S_EV;
				end
			end
			fmi_pkg::S_S_EV: begin
				if (!is_term && sym_rd_q == code_q) begin
					if (idx_q < low_q) rl_d = rl_q + 13'd1;
					if (idx_q < high_q) rh_d = rh_q + 13'd1;
				end
				idx_d = idx_q + 13'd1;
				state_d = fmi_pkg::S_S_RD;
			end
			fmi_pkg::S_L_RD: begin
				state_d = fmi_pkg::S_L_EV;
			end
			fmi_pkg::S_L_EV: begin
				if (mk_rd_q) begin
					text_d = sp_rd_q + steps_q[11:0];
					state_d = fmi_pkg::S_DONE;
				end else if (steps_q >= cnt_q) begin
					status_d = fmi_pkg::ST_LOC_LOOP;
					state_d = fmi_pkg::S_DONE;
				end else begin
					j_d = lf_rd_q;
					steps_d = steps_q + 13'd1;
					state_d = fmi_pkg::S_L_RD;
				end
			end
			default: begin
				state_d = fmi_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			seen_q <= '0;
			term_q <= '0;
			low_q <= '0;
			high_q <= '0;
			built_q <= 1'b0;
			si_q <= 13'd32;
			out_v_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			seen_q <= seen_d;
			term_q <= term_d;
			low_q <= low_d;
			high_q <= high_d;
			built_q <= built_d;
			if (cfg_we) si_q <= cfg_data;
			if (load_out) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		i_q <= i_d;
		m_q <= m_d;
		acc_q <= acc_d;
		j_q <= j_d;
		rl_q <= rl_d;
		rh_q <= rh_d;
		steps_q <= steps_d;
		code_q <= code_d;
		status_q <= status_d;
		text_q <= text_d;
		if (load_out) begin
			o_status_q <= status_q;
			o_low_q <= low_q;
			o_high_q <= high_q;
			o_text_q <= text_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_we) sym_mem[cnt_q[11:0]] <= sym_wd;
		sym_rd_q <= sym_mem[idx_q[11:0]];
	end

	always_ff @(posedge clk) begin
		if (tl_we) tl_mem[tl_wa] <= tl_wd;
		tl_rd_q <= tl_mem[tl_ra];
	end

	always_ff @(posedge clk) begin
		if (fc_we) fc_mem[fc_wa] <= fc_wd;
		fc_rd_q <= fc_mem[fc_ra];
	end

	always_ff @(posedge clk) begin
		if (lf_we) lf_mem[lf_wa] <= lf_wd;
		lf_rd_q <= lf_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (mk_we) mk_mem[mk_wa] <= mk_wd;
		mk_rd_q <= mk_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (sp_we) sp_mem[sp_wa] <= sp_wd;
		sp_rd_q <= sp_mem[j_q];
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = o_status_q;
	assign rsp.interval_low = o_low_q;
	assign rsp.interval_high = o_high_q;
	assign rsp.text_position = o_text_q;

	`FMI_ASSERT_NOW(a_rsp_from_done, $rose(out_v_q), $past(state_q == fmi_pkg::S_DONE), "result beat without finished command")
	`FMI_ASSERT_NOW(a_len_bound, 1'b1, cnt_q <= 13'd4096, "loaded length beyond capacity")
	`FMI_ASSERT_NOW(a_walk_in_range, state_q == fmi_pkg::S_L_EV, 13'(j_q) < cnt_q, "locate walk left the loaded rows")
	`FMI_ASSERT_NEXT(a_load_unbuilds, acc_in && req.cmd == fmi_pkg::CMD_LOAD && !cnt_q[12], !built_q, "load left index built")

endmodule
`default_nettype wire

// ===== tb/sv/fm_index_locate_checker.sv =====
// checker for the fm index block: predicts every response beat and compares it
`timescale 1ns / 1ps
`default_nettype none
module fm_index_locate_checker (
	input wire logic clk,
	input wire logic arst_n,
	fmi_req_if req,
	fmi_rsp_if rsp,
	input wire logic cfg_we,
	input wire logic [12:0] cfg_data,
	output int fail_count,
	output int outstanding,
	output int beats_checked
);

	typedef struct packed {
		fmi_pkg::status_t status;
		logic [12:0] lo;
		logic [12:0] hi;
		logic [11:0] pos;
	} rsp_beat_t;

	// mirrored index state
	logic [7:0] sym_mem [fmi_pkg::MaxLen];
	int unsigned len, term_row, term_seen;
	int unsigned first_col [257];
	bit marked [fmi_pkg::MaxLen];
	int unsigned sample_pos [fmi_pkg::MaxLen+1];
	int unsigned lf_link [fmi_pkg::MaxLen];
	int unsigned tally [256];
	int unsigned iv_low, iv_high, spacing;
	bit built;
	rsp_beat_t pending_rsp [$];

	function automatic int unsigned sym_code(logic [7:0] b);
		return (b == 8'd0) ? 255 : int'(b) - 1;
	endfunction

	function automatic int unsigned rank_upto(int unsigned k, int unsigned p);
		int unsigned lim, r;
		lim = (p < len) ? p : len;
		r = 0;
		for (int unsigned q = 0; q < lim && q < fmi_pkg::MaxLen; q++)
			if (q != term_row && sym_mem[q] == k) r++;
		return r;
	endfunction

	function automatic fmi_pkg::status_t build_index();
		int unsigned n, si, acc, k, lf, i, j;
		n = len;
		si = spacing;
		if (term_seen != 1) begin
			built = 0;
			return fmi_pkg::ST_TERM_COUNT;
		end
		for (int c = 0; c < 256; c++) tally[c] = 0;
		for (int unsigned p = 0; p < n; p++)
			if (p != term_row) tally[sym_mem[p]]++;
		first_col[256] = 0;
		acc = 1;
		for (int c = 0; c < 256; c++) begin
			first_col[c] = acc;
			acc += tally[c];
		end
		for (int c = 0; c < 256; c++) tally[c] = 0;
		for (int unsigned p = 0; p < n; p++) begin
			lf = 0;
			if (p != term_row) begin
				k = sym_mem[p];
				lf = first_col[k] + tally[k];
				tally[k]++;
			end
			if (lf >= n) lf = 0;
			lf_link[p] = lf;
			marked[p] = 0;
		end
		if (si > 0) begin
			i = n - 1;
			j = 0;
			while (i > 0) begin
				if (i % si == 0) marked[j] = 1;
				j = lf_link[j];
				i--;
			end
			marked[j] = 1;
			i = n - 1;
			j = 0;
			while (i > 0) begin
				if (marked[j]) sample_pos[j] = i;
				j = lf_link[j];
				i--;
			end
			sample_pos[j] = 0;
		end
		built = 1;
		iv_low = 0;
		iv_high = n;
		return fmi_pkg::ST_OK;
	endfunction

	function automatic rsp_beat_t predict_rsp(fmi_pkg::cmd_t c, logic [7:0] sym, logic np,
		logic [11:0] r);
		rsp_beat_t e;
		int unsigned k, i, steps;
		e.status = fmi_pkg::ST_OK;
		e.pos = '0;
		case (c)
			fmi_pkg::CMD_LOAD: begin
				if (len >= fmi_pkg::MaxLen) begin
					e.status = fmi_pkg::ST_LOAD_FULL;
				end else begin
					if (sym == 8'd0) begin
						sym_mem[len] = 8'd0;
						term_row = len;
						term_seen++;
					end else begin
						sym_mem[len] = 8'(sym_code(sym));
					end
					len++;
					built = 0;
				end
			end
			fmi_pkg::CMD_BUILD: e.status = build_index();
			fmi_pkg::CMD_SEARCH: begin
				if (!built) e.status = fmi_pkg::ST_NOT_BUILT;
				else if (sym == 8'd0) e.status = fmi_pkg::ST_PAT_ZERO;
				else begin
					k = sym_code(sym);
					if (np) begin
						iv_low = 0;
						iv_high = len;
					end
					iv_low = (first_col[k] + rank_upto(k, iv_low)) & 'h1FFF;
					iv_high = (first_col[k] + rank_upto(k, iv_high)) & 'h1FFF;
				end
			end
			default: begin
				if (!built || spacing == 0) e.status = fmi_pkg::ST_NOT_BUILT;
				else if (r >= len) e.status = fmi_pkg::ST_ROW_RANGE;
				else begin
					i = r;
					steps = 0;
					while (!marked[i]) begin
						i = lf_link[i];
						steps++;
						if (steps > len) begin
							e.status = fmi_pkg::ST_LOC_LOOP;
							break;
						end
					end
					if (e.status == fmi_pkg::ST_OK) e.pos = 12'(sample_pos[i] + steps);
				end
			end
		endcase
		e.lo = iv_low[12:0];
		e.hi = iv_high[12:0];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want, got, next_beat;
		if (!arst_n) begin
			len = 0;
			term_row = 0;
			term_seen = 0;
			iv_low = 0;
			iv_high = 0;
			built = 0;
			spacing = 32;
			pending_rsp.delete();
			fail_count <= 0;
			beats_checked <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status = rsp.status;
				got.lo = rsp.interval_low;
				got.hi = rsp.interval_high;
				got.pos = rsp.text_position;
				if (pending_rsp.size() == 0) begin
					if (fail_count < 10)
						$display("tb: unexpected response beat %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_rsp.pop_front();
					if (want !== got) begin
						if (fail_count < 10)
							$display({"tb: mismatch status %0d/%0d low %0d/%0d",
								" high %0d/%0d pos %0d/%0d (exp/act)"},
								want.status, got.status, want.lo, got.lo,
								want.hi, got.hi, want.pos, got.pos);
						fail_count <= fail_count + 1;
					end
					beats_checked <= beats_checked + 1;
				end
			end
			if (req.valid && req.ready) begin
				next_beat = predict_rsp(req.cmd, req.symbol, req.new_pattern, req.row);
				pending_rsp.insert(pending_rsp.size(), next_beat);
			end
			if (cfg_we) spacing = cfg_data;
			outstanding <= pending_rsp.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/fm_index_search_locate_tb.sv =====
// top of the fm index testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module fm_index_search_locate_tb;

	localparam int StallLimit = 250000;
	localparam int TextLen = 19;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [12:0] cfg_data = '0;

	fmi_req_if req ();
	fmi_rsp_if rsp ();

	int fail_count, outstanding, beats_checked;
	int src_idle = 16, dst_idle = 49;
	int hold_ticket = 0, hold_seen = 0, hold_left = 0;
	int items_sent = 0, searches = 0, locates = 0, quiet = 0;
	int unsigned n_loaded = 0;
	logic [7:0] text [TextLen];
	logic [7:0] ring [TextLen+1];
	int rot [TextLen+1];

	fm_index_search_locate dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	fm_index_locate_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.beats_checked(beats_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= 400;
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= dst_idle);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= StallLimit) begin
			$display("tb: no beat moved for %0d cycles", quiet);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_cmd(fmi_pkg::cmd_t c, logic [7:0] sym, logic np, logic [11:0] r);
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= c;
		req.symbol <= sym;
		req.new_pattern <= np;
		req.row <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		if (c == fmi_pkg::CMD_SEARCH) searches++;
		if (c == fmi_pkg::CMD_LOCATE) locates++;
		if (c == fmi_pkg::CMD_LOAD && n_loaded < fmi_pkg::MaxLen) n_loaded++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_spacing(logic [12:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic bit rot_less(int a, int b);
		for (int k = 0; k <= TextLen; k++) begin
			if (ring[(a+k)%(TextLen+1)] != ring[(b+k)%(TextLen+1)])
				return ring[(a+k)%(TextLen+1)] < ring[(b+k)%(TextLen+1)];
		end
		return 0;
	endfunction

	// pattern taken from the text, fed last byte first
	task automatic search_substring();
		int plen, start;
		plen = $urandom_range(1, 5);
		start = $urandom_range(0, TextLen - plen);
		for (int k = plen - 1; k >= 0; k--)
			send_cmd(fmi_pkg::CMD_SEARCH, text[start+k], (k == plen - 1), 12'($urandom));
	endtask

	task automatic random_action(bit allow_load);
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) search_substring();
		else if (pick < 60)
			send_cmd(fmi_pkg::CMD_SEARCH, 8'($urandom), 1'($urandom), 12'($urandom));
		else if (pick < 80) send_cmd(fmi_pkg::CMD_LOCATE, 8'($urandom), 1'($urandom),
			12'($urandom_range(0, n_loaded - 1)));
		else if (pick < 85)
			send_cmd(fmi_pkg::CMD_LOCATE, 8'($urandom), 1'($urandom), 12'($urandom));
		else if (pick < 93 || !allow_load) send_cmd(fmi_pkg::CMD_BUILD, 8'($urandom),
			1'($urandom), 12'($urandom));
		else send_cmd(fmi_pkg::CMD_LOAD, 8'($urandom_range(1, 255)), 1'($urandom),
			12'($urandom));
	endtask

	initial begin
		int tmp, j, goal;
		logic [7:0] alpha [4];
		req.valid <= 1'b0;
		req.cmd <= fmi_pkg::CMD_LOAD;
		req.symbol <= '0;
		req.new_pattern <= 1'b0;
		req.row <= '0;
		alpha = '{8'h61, 8'h63, 8'h67, 8'h74};
		for (int k = 0; k < TextLen; k++) begin
			tmp = $urandom_range(99);
			text[k] = (tmp < 4) ? 8'h01 : (tmp < 8) ? 8'hFF : alpha[$urandom_range(3)];
			ring[k] = text[k];
		end
		ring[TextLen] = 8'h00;
		for (int k = 0; k <= TextLen; k++) rot[k] = k;
		// insertion sort of rotations gives the suffix order
		for (int k = 1; k <= TextLen; k++) begin
			tmp = rot[k];
			j = k - 1;
			while (j >= 0 && rot_less(tmp, rot[j])) begin
				rot[j+1] = rot[j];
				j--;
			end
			rot[j+1] = tmp;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unbuilt and empty index, then load, build, spacing and row corner cases
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_SEARCH, 8'h41, 1'b1, 12'h000);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'h000);
		for (int k = 0; k <= TextLen; k++)
			send_cmd(fmi_pkg::CMD_LOAD, ring[(rot[k] + TextLen) % (TextLen+1)], 1'b0,
				12'h000);
		send_cmd(fmi_pkg::CMD_BUILD, 8'hFF, 1'b1, 12'hFFF);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'h000);
		set_spacing(13'd1);
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		search_substring();
		send_cmd(fmi_pkg::CMD_SEARCH, 8'h00, 1'b1, 12'h000);
		send_cmd(fmi_pkg::CMD_SEARCH, 8'hFF, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'(n_loaded - 1));
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'hFFF);
		set_spacing(13'd0);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		set_spacing(13'd4096);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'h001);
		set_spacing(13'd4095);
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_LOCATE, 8'h00, 1'b0, 12'h002);

		// random, three idling regimes
		goal = items_sent + 90;
		set_spacing(13'($urandom_range(2, 5)));
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		while (items_sent < goal - 60) random_action(1'b0);
		src_idle = 49;
		dst_idle = 16;
		set_spacing(13'($urandom_range(1, 8)));
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		while (items_sent < goal - 30) random_action(1'b1);
		src_idle = 0;
		dst_idle = 0;
		set_spacing(13'($urandom_range(1, 3)));
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		hold_ticket <= hold_ticket + 1;
		while (items_sent < goal) random_action(1'b1);

		// a second terminator breaks the build
		send_cmd(fmi_pkg::CMD_LOAD, 8'h00, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_BUILD, 8'h00, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_LOAD, 8'h5A, 1'b0, 12'h000);
		send_cmd(fmi_pkg::CMD_LOAD, 8'h00, 1'b0, 12'h000);
		drain();
		repeat (20) @(posedge clk);

		$display("tb: %0d commands, %0d responses checked", items_sent, beats_checked);
		$display("tb: %0d search steps, %0d locates, loaded length %0d", searches, locates,
			n_loaded);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
